>>> hw/rtl/tlf_pkg.sv
// tlf_pkg: shared constants and types for the text line folder
// no dependencies; used by every module under hw/rtl

package tlf_pkg;

    localparam int MAX_WIDTH_DEF = 32;
    localparam int CFG_W         = 6;
    localparam int CHAR_W        = 8;

    localparam logic [CFG_W-1:0]  LINE_WIDTH_RESET = 6'd20;

    localparam logic [CHAR_W-1:0] CH_NL  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SP  = 8'd32;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_SHOW,
        ST_NL,
        ST_POST,
        ST_APPEND
    } state_t;

    // what happens to the pending line once the emitted part has gone out
    typedef enum logic [1:0] {
        ACT_CLEAR,
        ACT_HARD,
        ACT_SPLIT
    } act_t;

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return (c == CH_SP) || (c == CH_TAB);
    endfunction

endpackage

>>> hw/rtl/text_line_folder_core.sv
// text_line_folder_core: top level of the text line folder, sequencer and state
// depends on tlf_pkg, tlf_line_ram and tlf_ring_unit
//
// Folds a byte stream into lines no wider than line_width columns (0 acts as 1,
// values above MAX_WIDTH act as MAX_WIDTH). Leading blanks of each line are
// dropped; a full line breaks at a blank byte, at the last blank in the line or
// hard at the column, and a newline flushes the line. The pending line lives in
// a ring buffer of MAX_WIDTH bytes, so a break at a blank only moves the ring
// base and never copies bytes. One sequencer drives a single modular adder that
// forms every buffer address. A stored byte is accepted in idle and then written
// in the append state; a dropped blank is only accepted. A byte that folds or
// flushes is accepted, each emitted line byte is read (the read port is
// registered) and then shown, the newline follows, the line is updated, and the
// byte itself is appended when it is stored; the output may stall the show and
// newline states. in_ready is high only while the sequencer is idle.
// line_width is written with cfg_we.

module text_line_folder_core #(
    parameter int MAX_WIDTH = tlf_pkg::MAX_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tlf_pkg::CFG_W-1:0]   line_width,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [tlf_pkg::CHAR_W-1:0]  in_char,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [tlf_pkg::CHAR_W-1:0]  out_char,
    output logic                        out_last
);

    localparam int IDX_W = $clog2(MAX_WIDTH);
    localparam int LEN_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = tlf_pkg::CFG_W + 1;

    tlf_pkg::state_t                state_reg, state_next;
    tlf_pkg::act_t                  act_reg, act_next;
    logic [tlf_pkg::CFG_W-1:0]      width_reg;
    logic [LEN_W-1:0]               len_reg, len_next;
    logic [IDX_W-1:0]               base_reg, base_next;
    logic [IDX_W-1:0]               bpos_reg, bpos_next;
    logic                           bseen_reg, bseen_next;
    logic                           skip_reg, skip_next;
    logic [LEN_W-1:0]               cnt_reg, cnt_next;
    logic [LEN_W-1:0]               k_reg, k_next;
    logic [LEN_W-1:0]               cut_reg, cut_next;
    logic [tlf_pkg::CHAR_W-1:0]     char_reg, char_next;

    logic [LEN_W-1:0]               eff_width;
    logic [LEN_W-1:0]               ring_off;
    logic [IDX_W-1:0]               ring_idx;
    logic                           ram_we;
    logic                           ram_re;
    logic [tlf_pkg::CHAR_W-1:0]     ram_rdata;

    // clamp the configured width into 1..MAX_WIDTH
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_width = LEN_W'(1);
        end
        else if (CMP_W'(width_reg) > CMP_W'(MAX_WIDTH))
        begin
            eff_width = LEN_W'(MAX_WIDTH);
        end
        else
        begin
            eff_width = LEN_W'(width_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= tlf_pkg::LINE_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            width_reg <= line_width;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlf_pkg::ST_IDLE;
            act_reg   <= tlf_pkg::ACT_CLEAR;
            len_reg   <= '0;
            base_reg  <= '0;
            bpos_reg  <= '0;
            bseen_reg <= 1'b0;
            skip_reg  <= 1'b1;
            cnt_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            act_reg   <= act_next;
            len_reg   <= len_next;
            base_reg  <= base_next;
            bpos_reg  <= bpos_next;
            bseen_reg <= bseen_next;
            skip_reg  <= skip_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cut_reg  <= cut_next;
        char_reg <= char_next;
    end

    always_comb
    begin
        logic             nl;
        logic             bl;
        logic [LEN_W-1:0] cnt;

        state_next = state_reg;
        act_next   = act_reg;
        len_next   = len_reg;
        base_next  = base_reg;
        bpos_next  = bpos_reg;
        bseen_next = bseen_reg;
        skip_next  = skip_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        cut_next   = cut_reg;
        char_next  = char_reg;
        ring_off   = len_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        out_last   = 1'b0;
        out_char   = ram_rdata;
        nl         = (in_char == tlf_pkg::CH_NL);
        bl         = tlf_pkg::is_blank(in_char);
        cnt        = len_reg;

        unique case (state_reg)
            tlf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    char_next = in_char;
                    k_next    = '0;
                    if (nl)
                    begin
                        act_next   = tlf_pkg::ACT_CLEAR;
                        bseen_next = 1'b0;
                        bpos_next  = '0;
                        skip_next  = 1'b1;
                        cnt_next   = cnt;
                        state_next = (cnt == '0) ? tlf_pkg::ST_NL : tlf_pkg::ST_RD;
                    end
                    else if (bl && skip_reg)
                    begin
                        state_next = tlf_pkg::ST_IDLE;
                    end
                    else if (len_reg >= eff_width)
                    begin
                        skip_next  = 1'b0;
                        bseen_next = 1'b0;
                        bpos_next  = '0;
                        if (bl)
                        begin
                            // blank at full width: emit and skip the blank run
                            act_next  = tlf_pkg::ACT_CLEAR;
                            skip_next = 1'b1;
                        end
                        else if (bseen_reg && (LEN_W'(bpos_reg) < len_reg))
                        begin
                            act_next = tlf_pkg::ACT_SPLIT;
                            cnt      = LEN_W'(bpos_reg);
                            cut_next = LEN_W'(bpos_reg) + LEN_W'(1);
                        end
                        else
                        begin
                            act_next = tlf_pkg::ACT_HARD;
                        end
                        cnt_next   = cnt;
                        state_next = (cnt == '0) ? tlf_pkg::ST_NL : tlf_pkg::ST_RD;
                    end
                    else
                    begin
                        skip_next = 1'b0;
                        if (bl)
                        begin
                            bpos_next  = IDX_W'(len_reg);
                            bseen_next = 1'b1;
                        end
                        state_next = tlf_pkg::ST_APPEND;
                    end
                end
            end

            tlf_pkg::ST_RD:
            begin
                ring_off   = k_reg;
                ram_re     = 1'b1;
                state_next = tlf_pkg::ST_SHOW;
            end

            tlf_pkg::ST_SHOW:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    k_next     = k_reg + LEN_W'(1);
                    state_next = ((k_reg + LEN_W'(1)) == cnt_reg) ? tlf_pkg::ST_NL
                                                                  : tlf_pkg::ST_RD;
                end
            end

            tlf_pkg::ST_NL:
            begin
                out_valid = 1'b1;
                out_last  = 1'b1;
                out_char  = tlf_pkg::CH_NL;
                if (out_ready)
                begin
                    state_next = tlf_pkg::ST_POST;
                end
            end

            tlf_pkg::ST_POST:
            begin
                unique case (act_reg)
                    tlf_pkg::ACT_CLEAR:
                    begin
                        len_next   = '0;
                        state_next = tlf_pkg::ST_IDLE;
                    end
                    tlf_pkg::ACT_HARD:
                    begin
                        len_next   = '0;
                        state_next = tlf_pkg::ST_APPEND;
                    end
                    tlf_pkg::ACT_SPLIT:
                    begin
                        // the tail after the blank becomes the start of the line
                        ring_off   = cut_reg;
                        base_next  = ring_idx;
                        len_next   = len_reg - cut_reg;
                        state_next = tlf_pkg::ST_APPEND;
                    end
                    default:
                    begin
                        state_next = tlf_pkg::ST_IDLE;
                    end
                endcase
            end

            tlf_pkg::ST_APPEND:
            begin
                ring_off   = len_reg;
                ram_we     = 1'b1;
                len_next   = len_reg + LEN_W'(1);
                state_next = tlf_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = tlf_pkg::ST_IDLE;
            end
        endcase
    end

    tlf_ring_unit #(
        .DEPTH (MAX_WIDTH),
        .IDX_W (IDX_W),
        .LEN_W (LEN_W)
    ) u_ring (
        .base   (base_reg),
        .offset (ring_off),
        .idx    (ring_idx)
    );

    tlf_line_ram #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ring_idx),
        .wdata (char_reg),
        .re    (ram_re),
        .raddr (ring_idx),
        .rdata (ram_rdata)
    );

    // no new transaction while a result is on offer
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input accepted while output pending");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_WIDTH))
        else $error("line length beyond buffer depth");

    a_base_bound: assert property (@(posedge clk) disable iff (!rst_n)
        base_reg < IDX_W'(MAX_WIDTH - 1) || base_reg == IDX_W'(MAX_WIDTH - 1))
        else $error("ring base out of range");

    a_nl_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_char == tlf_pkg::CH_NL)
            |=> (state_reg == tlf_pkg::ST_RD || state_reg == tlf_pkg::ST_NL))
        else $error("newline did not start a flush");

    a_last_is_nl: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_last) |-> (out_char == tlf_pkg::CH_NL))
        else $error("last result is not a newline");

endmodule

>>> hw/rtl/tlf_line_ram.sv
// tlf_line_ram: pending line buffer, one write port and one registered read port
// depends on tlf_pkg for the byte width

module tlf_line_ram #(
    parameter int DEPTH  = tlf_pkg::MAX_WIDTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [tlf_pkg::CHAR_W-1:0]  wdata,
    input  logic                        re,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [tlf_pkg::CHAR_W-1:0]  rdata
);

    logic [tlf_pkg::CHAR_W-1:0] mem [DEPTH];
    logic [tlf_pkg::CHAR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while the output is stalled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/tlf_ring_unit.sv
// tlf_ring_unit: shared modular adder that maps a line offset onto the ring buffer
// depends on tlf_pkg for the default depth

module tlf_ring_unit #(
    parameter int DEPTH  = tlf_pkg::MAX_WIDTH_DEF,
    parameter int IDX_W  = $clog2(DEPTH),
    parameter int LEN_W  = $clog2(DEPTH + 1)
) (
    input  logic [IDX_W-1:0] base,
    input  logic [LEN_W-1:0] offset,
    output logic [IDX_W-1:0] idx
);

    localparam int SUM_W = LEN_W + 1;

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] wrapped;

    // base < DEPTH and offset <= DEPTH, so one subtract is enough
    assign sum     = SUM_W'(base) + SUM_W'(offset);
    assign wrapped = (sum >= SUM_W'(DEPTH)) ? (sum - SUM_W'(DEPTH)) : sum;
    assign idx     = wrapped[IDX_W-1:0];

endmodule
